// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the button press detector.
// Each macro checks a property on the rising edge of clk, outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property that relates signals in the same or later cycles.
`define BPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication whose consequent holds in the same cycle.
`define BPD_ASSERT_IMPL(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

`endif

// ===== sv/bpd_pkg.sv =====
// Package for the button press detector: phase and opcode types,
// register map, reset values and the configuration struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WATCH   = 2'd1,
    PH_CONFIRM = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_START  = 1'b1
  } op_t;

  localparam int ADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int TICK_W = 8;
  localparam int COUNT_W = 16;

  localparam logic [1:0] REG_POLL     = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  localparam logic [TICK_W-1:0]  POLL_RESET     = 8'd20;
  localparam logic [TICK_W-1:0]  DEBOUNCE_RESET = 8'd30;
  localparam logic [COUNT_W-1:0] TIMEOUT_RESET  = 16'd0;

  typedef struct packed {
    logic [TICK_W-1:0]  poll_ticks;
    logic [TICK_W-1:0]  debounce_ticks;
    logic [COUNT_W-1:0] timeout_ticks;
  } cfg_t;

  // Ticks left to wait after an action; a period of zero acts as one.
  function automatic logic [TICK_W-1:0] wait_of(input logic [TICK_W-1:0] period);
    wait_of = (period == '0) ? '0 : period - TICK_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== sv/bpd_cfg.sv =====
// Configuration register file of the button press detector, APB-style port.
// Depends on bpd_pkg for the register map and reset values.
`timescale 1ns / 1ps
`default_nettype none

module bpd_cfg
  import bpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_ticks     <= POLL_RESET;
      cfg.debounce_ticks <= DEBOUNCE_RESET;
      cfg.timeout_ticks  <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_POLL:     cfg.poll_ticks     <= pwdata[TICK_W-1:0];
        REG_DEBOUNCE: cfg.debounce_ticks <= pwdata[TICK_W-1:0];
        REG_TIMEOUT:  cfg.timeout_ticks  <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_POLL:     prdata = PDATA_W'(cfg.poll_ticks);
      REG_DEBOUNCE: prdata = PDATA_W'(cfg.debounce_ticks);
      REG_TIMEOUT:  prdata = PDATA_W'(cfg.timeout_ticks);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/bpd_core.sv =====
// Wait sequencer of the button press detector: phase, edge and candidate
// masks, elapsed and interval counters. Depends on bpd_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bpd_core
  import bpd_pkg::*;
#(
  parameter int BUTTONS = 6
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire op_t                opcode,
  input  wire logic [BUTTONS-1:0] pressed,
  input  wire cfg_t               cfg,
  output logic                    res_valid,
  output logic      [BUTTONS-1:0] res_mask,
  output logic                    res_timeout
);

  phase_t               phase, phase_next;
  logic [BUTTONS-1:0]   previous_pressed, previous_pressed_next;
  logic [BUTTONS-1:0]   candidate_mask, candidate_mask_next;
  logic [COUNT_W-1:0]   elapsed_count, elapsed_count_next;
  logic [TICK_W-1:0]    interval_count, interval_count_next;
  logic [BUTTONS-1:0]   edge_mask;
  logic [BUTTONS-1:0]   held_mask;
  logic                 timeout_hit;

  assign edge_mask   = pressed & ~previous_pressed;
  assign held_mask   = pressed & candidate_mask;
  assign timeout_hit = (cfg.timeout_ticks != '0) && (elapsed_count >= cfg.timeout_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      previous_pressed <= '0;
      candidate_mask   <= '0;
      elapsed_count    <= '0;
      interval_count   <= '0;
    end else begin
      phase            <= phase_next;
      previous_pressed <= previous_pressed_next;
      candidate_mask   <= candidate_mask_next;
      elapsed_count    <= elapsed_count_next;
      interval_count   <= interval_count_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    previous_pressed_next = previous_pressed;
    candidate_mask_next   = candidate_mask;
    elapsed_count_next    = elapsed_count;
    interval_count_next   = interval_count;
    res_valid             = 1'b0;
    res_mask              = '0;
    res_timeout           = 1'b0;

    if (fire) begin
      if (opcode == OP_START) begin
        previous_pressed_next = pressed;
        candidate_mask_next   = '0;
        elapsed_count_next    = '0;
        interval_count_next   = '0;
        phase_next            = PH_WATCH;
      end else if (phase != PH_IDLE) begin
        if (interval_count != '0) begin
          interval_count_next = interval_count - TICK_W'(1);
        end else begin
          unique case (phase)
            PH_WATCH: begin
              if (timeout_hit) begin
                res_valid   = 1'b1;
                res_timeout = 1'b1;
                phase_next  = PH_IDLE;
              end else begin
                previous_pressed_next = pressed;
                if (edge_mask != '0) begin
                  candidate_mask_next = edge_mask;
                  interval_count_next = wait_of(cfg.debounce_ticks);
                  phase_next          = PH_CONFIRM;
                end else begin
                  interval_count_next = wait_of(cfg.poll_ticks);
                end
              end
            end
            PH_CONFIRM: begin
              if (held_mask != '0) begin
                candidate_mask_next = held_mask;
                phase_next          = PH_RELEASE;
              end else begin
                phase_next = PH_WATCH;
              end
              interval_count_next = wait_of(cfg.poll_ticks);
            end
            PH_RELEASE: begin
              if (held_mask == '0) begin
                res_valid  = 1'b1;
                res_mask   = candidate_mask;
                phase_next = PH_IDLE;
              end else begin
                interval_count_next = wait_of(cfg.poll_ticks);
              end
            end
            default: ;
          endcase
        end
        if (elapsed_count != '1) begin
          elapsed_count_next = elapsed_count + COUNT_W'(1);
        end
      end
    end
  end

  `BPD_ASSERT_IMPL(a_idle_no_result, phase == PH_IDLE, !res_valid, "result from idle phase")
  `BPD_ASSERT(a_result_ends_wait, res_valid |=> phase == PH_IDLE, "wait not ended by result")
  `BPD_ASSERT_IMPL(a_idle_interval_clear, phase == PH_IDLE, interval_count == '0, "interval left in idle")
  `BPD_ASSERT_IMPL(a_release_has_cand, phase == PH_RELEASE, candidate_mask != '0, "release with no button")

endmodule

`default_nettype wire

// ===== sv/button_press_detector.sv =====
// Button press detector: debounced press or timeout on BUTTONS active-low pads.
// A word is held in the input register; its result word is registered in the result register.
// Throughput: one word per cycle; the input and result registers stall only
// while the result register holds a word not yet taken.
// Reset: synchronous, active high; clears phase, counters and masks, loads
// poll 20, debounce 30, timeout 0. Depends on bpd_pkg, bpd_cfg, bpd_core.
`timescale 1ns / 1ps
`default_nettype none

module button_press_detector
  import bpd_pkg::*;
#(
  parameter int BUTTONS = 6,
  localparam int DATA_W = ((BUTTONS + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [DATA_W-1:0]  s_tdata,   // pad_levels
  input  wire logic [0:0]         s_tuser,   // opcode
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic      [DATA_W-1:0]  m_tdata,   // pressed_mask
  output logic      [0:0]         m_tuser,   // timed_out
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t               cfg;
  logic               in_valid;
  op_t                in_op;
  logic [BUTTONS-1:0] in_pressed;
  logic               advance;
  logic               fire;
  logic               res_valid;
  logic [BUTTONS-1:0] res_mask;
  logic               res_timeout;
  logic [BUTTONS-1:0] out_mask;
  logic               out_timeout;

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op      <= op_t'(s_tuser);
      in_pressed <= ~s_tdata[BUTTONS-1:0];
    end
  end

  bpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpd_core #(
    .BUTTONS (BUTTONS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .opcode      (in_op),
    .pressed     (in_pressed),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res_mask    (res_mask),
    .res_timeout (res_timeout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && res_valid) begin
      out_mask    <= res_mask;
      out_timeout <= res_timeout;
    end
  end

  assign m_tdata = DATA_W'(out_mask);
  assign m_tuser = out_timeout;

endmodule

`default_nettype wire

// ===== tb/sv/tb_button_press_detector.sv =====
// Testbench for button_press_detector: a directed table, then random press sequences,
// each result word checked against the table or a cycle-free predictor of the detector.
// Depends on bpd_pkg and the button_press_detector RTL.
`timescale 1ns / 1ps

module tb_button_press_detector;
  import bpd_pkg::*;

  localparam int DATA_W = 8;

  typedef struct packed {
    logic [5:0] mask;
    logic       timed_out;
  } press_report_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] pads;
    logic       typed;
    logic       has_report;
    logic [5:0] mask;
    logic       timed_out;
  } dir_row_t;

  localparam dir_row_t DIRECTED [0:23] = '{
    '{OP_SAMPLE, 6'h3F, 1'b1, 1'b0, 6'h00, 1'b0},
    '{OP_START,  6'h3F, 1'b1, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h3E, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h3E, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h3E, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h3F, 1'b1, 1'b1, 6'h01, 1'b0},
    '{OP_START,  6'h3F, 1'b1, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h3F, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h3F, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h3F, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h3F, 1'b1, 1'b1, 6'h00, 1'b1},
    '{OP_START,  6'h00, 1'b1, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h00, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h20, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h00, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h3F, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h3F, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_START,  6'h3F, 1'b1, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h00, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_START,  6'h2A, 1'b1, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h00, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h00, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h15, 1'b0, 1'b0, 6'h00, 1'b0},
    '{OP_SAMPLE, 6'h3F, 1'b0, 1'b0, 6'h00, 1'b0}
  };

  logic               clk;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [DATA_W-1:0]  s_tdata = '0;   // pad_levels
  logic [0:0]         s_tuser = '0;   // opcode
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [DATA_W-1:0]  m_tdata;        // pressed_mask
  logic [0:0]         m_tuser;        // timed_out
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  button_press_detector i_dut (.*);

  // predictor state and its copy of the registers
  cfg_t         live_cfg;
  phase_t       mdl_phase;
  logic [5:0]   mdl_prev;
  logic [5:0]   mdl_cand;
  logic [15:0]  mdl_elapsed;
  logic [7:0]   mdl_wait;

  press_report_t awaited_reports [$];
  press_report_t head;
  int            mismatch_count = 0;
  int            src_idle_pct = 0;
  int            snk_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] ticks_to_wait(input logic [7:0] period);
    ticks_to_wait = (period == 8'd0) ? 8'd0 : period - 8'd1;
  endfunction

  function automatic bit detector_step(input op_t op, input logic [5:0] pads,
                                       output press_report_t rep);
    logic [5:0] now_pressed;
    logic [5:0] rise;
    bit         fired;
    now_pressed = ~pads;
    fired = 1'b0;
    rep = '0;
    if (op == OP_START) begin
      mdl_prev = now_pressed;
      mdl_cand = '0;
      mdl_elapsed = '0;
      mdl_wait = '0;
      mdl_phase = PH_WATCH;
      return 1'b0;
    end
    if (mdl_phase == PH_IDLE) return 1'b0;
    if (mdl_wait != 8'd0) begin
      mdl_wait = mdl_wait - 8'd1;
    end else begin
      case (mdl_phase)
        PH_WATCH: begin
          if (live_cfg.timeout_ticks != '0 && mdl_elapsed >= live_cfg.timeout_ticks) begin
            rep = '{6'h00, 1'b1};
            fired = 1'b1;
            mdl_phase = PH_IDLE;
          end else begin
            rise = now_pressed & ~mdl_prev;
            mdl_prev = now_pressed;
            if (rise != '0) begin
              mdl_cand = rise;
              mdl_wait = ticks_to_wait(live_cfg.debounce_ticks);
              mdl_phase = PH_CONFIRM;
            end else begin
              mdl_wait = ticks_to_wait(live_cfg.poll_ticks);
            end
          end
        end
        PH_CONFIRM: begin
          if ((now_pressed & mdl_cand) != '0) begin
            mdl_cand = now_pressed & mdl_cand;
            mdl_phase = PH_RELEASE;
          end else begin
            mdl_phase = PH_WATCH;
          end
          mdl_wait = ticks_to_wait(live_cfg.poll_ticks);
        end
        PH_RELEASE: begin
          if ((now_pressed & mdl_cand) == '0) begin
            rep = '{mdl_cand, 1'b0};
            fired = 1'b1;
            mdl_phase = PH_IDLE;
          end else begin
            mdl_wait = ticks_to_wait(live_cfg.poll_ticks);
          end
        end
        default: ;
      endcase
    end
    if (mdl_elapsed != 16'hFFFF) mdl_elapsed = mdl_elapsed + 16'd1;
    return fired;
  endfunction

  // check result words and drive the stall pattern
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual mask %h timed_out %b",
                 $time, m_tdata, m_tuser);
        mismatch_count++;
      end else begin
        head = awaited_reports.pop_front();
        if (m_tdata !== {2'b00, head.mask}) begin
          $display("%0t: pressed_mask mismatch: expected %h, actual %h",
                   $time, head.mask, m_tdata);
          mismatch_count++;
        end
        if (m_tuser !== head.timed_out) begin
          $display("%0t: timed_out mismatch: expected %b, actual %b",
                   $time, head.timed_out, m_tuser);
          mismatch_count++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic send_word(input op_t op, input logic [5:0] pads);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, pads};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic apply_word(input op_t op, input logic [5:0] pads);
    press_report_t rep;
    send_word(op, pads);
    if (detector_step(op, pads, rep)) awaited_reports.push_back(rep);
  endtask

  task automatic apb_read(input logic [1:0] idx, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %0d readback: expected %h, actual %h", $time, idx, want, prdata);
      mismatch_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    apb_read(idx, val);
  endtask

  task automatic set_config(input logic [7:0] poll, input logic [7:0] debounce,
                            input logic [15:0] timeout);
    apb_write(REG_POLL, {24'd0, poll});
    apb_write(REG_DEBOUNCE, {24'd0, debounce});
    apb_write(REG_TIMEOUT, {16'd0, timeout});
    live_cfg = '{poll, debounce, timeout};
  endtask

  // drop valid, drain the result side, then wait out the pipeline
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] poll, input logic [7:0] debounce,
                           input logic [15:0] timeout, input int src_pct,
                           input int snk_pct, input int budget);
    int         sent;
    int         left;
    int         dwell;
    int         span;
    logic [5:0] pads;
    settle();
    set_config(poll, debounce, timeout);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    span = int'(poll) + int'(debounce) + 2;
    sent = 0;
    while (sent < budget) begin
      pads = ($urandom_range(99) < 30) ? 6'($urandom) : 6'h3F;
      apply_word(OP_START, pads);
      sent++;
      left = $urandom_range(2, 4 * span);
      dwell = $urandom_range(1, span);
      while (left > 0 && sent < budget) begin
        dwell--;
        if (dwell == 0) begin
          dwell = $urandom_range(1, span);
          case ($urandom_range(9))
            0, 1, 2, 3: pads = 6'h3F;
            4, 5, 6:    pads = pads & ~(6'd1 << $urandom_range(5));
            default:    pads = 6'($urandom);
          endcase
        end
        sent++;
        if ($urandom_range(19) == 0) apply_word(OP_SAMPLE, 6'($urandom));
        else apply_word(OP_SAMPLE, pads);
        left--;
        if (mdl_phase == PH_IDLE && $urandom_range(3) != 0) left = 0;
      end
    end
  endtask

  initial begin
    dir_row_t      row;
    press_report_t rep;
    live_cfg = '{POLL_RESET, DEBOUNCE_RESET, TIMEOUT_RESET};
    mdl_phase = PH_IDLE;
    mdl_prev = '0;
    mdl_cand = '0;
    mdl_elapsed = '0;
    mdl_wait = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_read(REG_POLL, {24'd0, POLL_RESET});
    apb_read(REG_DEBOUNCE, {24'd0, DEBOUNCE_RESET});
    apb_read(REG_TIMEOUT, {16'd0, TIMEOUT_RESET});
    set_config(8'd1, 8'd1, 16'd3);

    for (int r = 0; r < 24; r++) begin
      row = DIRECTED[r];
      send_word(row.op, row.pads);
      if (row.typed) begin
        void'(detector_step(row.op, row.pads, rep));
        if (row.has_report) begin
          rep = '{row.mask, row.timed_out};
          awaited_reports.push_back(rep);
        end
      end else if (detector_step(row.op, row.pads, rep)) begin
        awaited_reports.push_back(rep);
      end
    end

    run_phase(8'd1,   8'd1,   16'd0,     0,  0, 150);
    run_phase(8'd2,   8'd3,   16'd40,   68,  0, 150);
    run_phase(8'd3,   8'd2,   16'd0,     0, 68, 150);
    run_phase(8'd1,   8'd4,   16'hFFFF,  7,  7, 150);
    run_phase(8'd255, 8'd255, 16'd500,   0,  0, 300);
    run_phase(8'd0,   8'd0,   16'd1,     7,  7, 120);
    run_phase(8'd5,   8'd1,   16'd30,   68,  0, 120);

    settle();
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
